// ===== src/spp_pkg.sv =====
`default_nettype none

package spp_pkg;

   // Count width that holds any saturated dimension up to 64.
   localparam int CNT_W        = 7;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int RESULT_LIMIT = 16;

   localparam int OPCODE_W  = 2;
   localparam int ROW_W     = 4;
   localparam int COL_W     = 4;
   localparam int MASK_W    = 16;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LEFT    = 2'd0,
      OP_RIGHT   = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_LEFT,
      CMD_RIGHT,
      CMD_COMPUTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] rows;
      logic [CNT_W-1:0] inner;
      logic [CNT_W-1:0] cols;
   } dims_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_ROWS  = 2'd0,
      CSR_INNER_SIZE = 2'd1,
      CSR_RIGHT_COLS = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/spp_front.sv =====
`default_nettype none

module spp_front (
   input  wire logic                       accept,
   input  wire logic [spp_pkg::OPCODE_W-1:0] opcode,
   input  wire logic [spp_pkg::ROW_W-1:0]  row,
   input  wire logic [spp_pkg::COL_W-1:0]  col,
   input  wire spp_pkg::dims_type          dims,
   output logic                            push,
   output spp_pkg::cmd_type                cmd
);
   import spp_pkg::*;

   logic [CNT_W-1:0] row_ext;
   logic [CNT_W-1:0] col_ext;

   assign row_ext = CNT_W'(row);
   assign col_ext = CNT_W'(col);

   // Entries outside the configured sizes are dropped here, so that the
   // back end never sees them.
   always_comb begin
      cmd.kind = CMD_LEFT;
      cmd.row  = row;
      cmd.col  = col;
      push     = 1'b0;
      case (opcode_type'(opcode))
         OP_LEFT: begin
            push = accept && (row_ext < dims.rows) && (col_ext < dims.inner);
         end
         OP_RIGHT: begin
            cmd.kind = CMD_RIGHT;
            push     = accept && (row_ext < dims.inner) && (col_ext < dims.cols);
         end
         OP_COMPUTE: begin
            cmd.kind = CMD_COMPUTE;
            push     = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/spp_queue.sv =====
`default_nettype none

module spp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire spp_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output spp_pkg::cmd_type      head_cmd,
   output logic                  not_empty,
   output logic                  full
);
   import spp_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;

   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/spp_back.sv =====
`default_nettype none

module spp_back #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_INNER = 16,
   parameter int MAX_COLS  = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire spp_pkg::dims_type          dims,
   input  wire logic                       cmd_valid,
   input  wire spp_pkg::cmd_type           cmd,
   output logic                            cmd_pop,
   output logic                            rsp_valid,
   output logic [spp_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [spp_pkg::MASK_W-1:0]      rsp_col_mask,
   output logic                            rsp_last
);
   import spp_pkg::*;

   localparam int RIDX_W = $clog2(MAX_ROWS);

   logic [MAX_INNER-1:0] left_store_ff  [MAX_ROWS];
   logic [MAX_INNER-1:0] left_store_in  [MAX_ROWS];
   logic [MAX_COLS-1:0]  right_store_ff [MAX_INNER];
   logic [MAX_COLS-1:0]  right_store_in [MAX_INNER];

   back_state_type     state_ff;
   back_state_type     state_in;
   logic [RIDX_W-1:0]  row_ff;
   logic [RIDX_W-1:0]  row_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ROW_W-1:0]   rsp_out_row_ff;
   logic [ROW_W-1:0]   rsp_out_row_in;
   logic [MASK_W-1:0]  rsp_col_mask_ff;
   logic [MASK_W-1:0]  rsp_col_mask_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   logic [CNT_W-1:0]     emit;
   logic [MAX_INNER-1:0] imask;
   logic [MAX_INNER-1:0] sel;
   logic [MAX_COLS-1:0]  cmask;
   logic [MAX_COLS-1:0]  acc;
   logic                 row_last;
   logic                 clear;

   // Result row for the current left row: OR of the selected right rows.
   always_comb begin
      emit = (dims.rows > CNT_W'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT) : dims.rows;
      for (int k = 0; k < MAX_INNER; k++) begin
         imask[k] = (CNT_W'(k) < dims.inner);
      end
      for (int j = 0; j < MAX_COLS; j++) begin
         cmask[j] = (CNT_W'(j) < dims.cols);
      end
      sel = left_store_ff[row_ff] & imask;
      acc = '0;
      for (int k = 0; k < MAX_INNER; k++) begin
         if (sel[k]) begin
            acc = acc | right_store_ff[k];
         end
      end
      acc      = acc & cmask;
      row_last = ((CNT_W'(row_ff) + CNT_W'(1)) == emit);
   end

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      cmd_pop         = 1'b0;
      clear           = 1'b0;
      left_store_in   = left_store_ff;
      right_store_in  = right_store_ff;
      rsp_valid_in    = 1'b0;
      rsp_out_row_in  = ROW_W'(row_ff);
      rsp_col_mask_in = MASK_W'(acc);
      rsp_last_in     = row_last;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_LEFT: begin
                     for (int r = 0; r < MAX_ROWS; r++) begin
                        for (int c = 0; c < MAX_INNER; c++) begin
                           if ((CNT_W'(r) == CNT_W'(cmd.row)) &&
                               (CNT_W'(c) == CNT_W'(cmd.col))) begin
                              left_store_in[r][c] = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_RIGHT: begin
                     for (int r = 0; r < MAX_INNER; r++) begin
                        for (int c = 0; c < MAX_COLS; c++) begin
                           if ((CNT_W'(r) == CNT_W'(cmd.row)) &&
                               (CNT_W'(c) == CNT_W'(cmd.col))) begin
                              right_store_in[r][c] = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_COMPUTE: begin
                     if (emit == '0) begin
                        clear = 1'b1;
                     end else begin
                        state_in = BACK_EMIT;
                        row_in   = '0;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         BACK_EMIT: begin
            rsp_valid_in = 1'b1;
            if (row_last) begin
               state_in = BACK_IDLE;
               clear    = 1'b1;
            end else begin
               row_in = row_ff + RIDX_W'(1);
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      if (clear) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            left_store_in[r] = '0;
         end
         for (int r = 0; r < MAX_INNER; r++) begin
            right_store_in[r] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_ROWS; r++) begin
            left_store_ff[r] <= '0;
         end
         for (int r = 0; r < MAX_INNER; r++) begin
            right_store_ff[r] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         rsp_valid_ff   <= rsp_valid_in;
         left_store_ff  <= left_store_in;
         right_store_ff <= right_store_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_row_ff  <= rsp_out_row_in;
      rsp_col_mask_ff <= rsp_col_mask_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_out_row_ff;
   assign rsp_col_mask = rsp_col_mask_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/sparsity_pattern_product_core.sv =====
// Channel   Ports                                      Transfer when
// ------    -----------------------------------------  -----------------------
// request   start, busy, req_opcode, req_row, req_col  start high, busy low
// result    rsp_valid, rsp_out_row, rsp_col_mask,      every cycle rsp_valid
//           rsp_last                                   is high (no stall)
// config    csr_valid, csr_ready, csr_index, csr_data  csr_valid and csr_ready
//
// A load transfer is taken by the back end in its idle state; a compute is dispatched
// from the idle state and then emits its rows back to back (min(left_rows, 16) rows),
// set by the single row walk over the left store.
// A four-entry command queue lets one transfer per cycle be taken until it fills;
// busy is high exactly while the queue is full.
// Reset is synchronous and clears both pattern stores and the queue.
// Results leave the output register for one cycle each; the receiver cannot stall.
`default_nettype none

module sparsity_pattern_product_core #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_INNER = 16,
   parameter int MAX_COLS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [spp_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [spp_pkg::ROW_W-1:0]     req_row,
   input  wire logic [spp_pkg::COL_W-1:0]     req_col,
   output logic                               rsp_valid,
   output logic [spp_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [spp_pkg::MASK_W-1:0]         rsp_col_mask,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [spp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spp_pkg::CFG_W-1:0]     csr_data
);
   import spp_pkg::*;

   // Configuration registers, reset to the full sixteen.
   logic [CFG_W-1:0] left_rows_ff;
   logic [CFG_W-1:0] left_rows_in;
   logic [CFG_W-1:0] inner_size_ff;
   logic [CFG_W-1:0] inner_size_in;
   logic [CFG_W-1:0] right_cols_ff;
   logic [CFG_W-1:0] right_cols_in;

   dims_type dims;
   logic     accept;
   logic     push;
   cmd_type  push_cmd;
   cmd_type  head_cmd;
   logic     pop;
   logic     not_empty;
   logic     full;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      left_rows_in  = left_rows_ff;
      inner_size_in = inner_size_ff;
      right_cols_in = right_cols_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LEFT_ROWS:  left_rows_in  = csr_data;
            CSR_INNER_SIZE: inner_size_in = csr_data;
            CSR_RIGHT_COLS: right_cols_in = csr_data;
            default: begin
               left_rows_in = left_rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= CFG_W'(16);
         inner_size_ff <= CFG_W'(16);
         right_cols_ff <= CFG_W'(16);
      end else begin
         left_rows_ff  <= left_rows_in;
         inner_size_ff <= inner_size_in;
         right_cols_ff <= right_cols_in;
      end
   end

   // Register values above the store sizes saturate to those sizes.
   always_comb begin
      dims.rows  = (CNT_W'(left_rows_ff) > CNT_W'(MAX_ROWS)) ?
                   CNT_W'(MAX_ROWS) : CNT_W'(left_rows_ff);
      dims.inner = (CNT_W'(inner_size_ff) > CNT_W'(MAX_INNER)) ?
                   CNT_W'(MAX_INNER) : CNT_W'(inner_size_ff);
      dims.cols  = (CNT_W'(right_cols_ff) > CNT_W'(MAX_COLS)) ?
                   CNT_W'(MAX_COLS) : CNT_W'(right_cols_ff);
   end

   assign busy   = full;
   assign accept = start && !busy;

   // Front end: range checks happen at transfer time, against the sizes
   // in force then.
   spp_front u_front (
      .accept (accept),
      .opcode (req_opcode),
      .row    (req_row),
      .col    (req_col),
      .dims   (dims),
      .push   (push),
      .cmd    (push_cmd)
   );

   spp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (not_empty),
      .full      (full)
   );

   // Back end: owns both pattern stores and walks the rows of a product.
   spp_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .dims         (dims),
      .cmd_valid    (not_empty),
      .cmd          (head_cmd),
      .cmd_pop      (pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_row  (rsp_out_row),
      .rsp_col_mask (rsp_col_mask),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ===== src/spp_checker.sv =====
`default_nettype none

module spp_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      busy,
   input wire logic                      rsp_valid,
   input wire logic [spp_pkg::ROW_W-1:0] rsp_out_row,
   input wire logic                      rsp_last
);

   // After reset the block is empty and quiet.
   assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("block not quiet after reset");

   // A product always starts at row zero.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_out_row == '0)
      else $error("product does not start at row zero");

   // Rows of one product come back to back in increasing order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_valid && (rsp_out_row == ($past(rsp_out_row) + 4'd1)))
      else $error("row sequence broken");

   // The final row is followed by a gap before any next product.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after final row");

endmodule

bind sparsity_pattern_product_core spp_checker u_spp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spp_pkg::*;

   // Cycles to let pass after the last expected row before the block is
   // considered idle. Loads produce no rows, so up to four queued commands
   // plus the one in the back end may still be in flight.
   localparam int SETTLE      = 16;
   localparam int ITEM_TARGET = 230;

   // One row of the product, as the block reports it.
   typedef struct {
      logic [ROW_W-1:0]  row;
      logic [MASK_W-1:0] mask;
      logic              last;
   } product_row_type;

   // Keeps its own copy of both pattern stores and the three dimension
   // registers. Every accepted command is applied here in order. A compute
   // queues the rows that the block must produce next.
   class product_predictor;
      logic [MASK_W-1:0] left_bits[16];
      logic [MASK_W-1:0] right_bits[16];
      logic [CFG_W-1:0]  dim_rows;
      logic [CFG_W-1:0]  dim_inner;
      logic [CFG_W-1:0]  dim_cols;
      product_row_type   rows_due[$];
      int                mismatches;
      int                rows_checked;
      int                products;

      function new();
         clear_stores();
         dim_rows     = 5'd16;
         dim_inner    = 5'd16;
         dim_cols     = 5'd16;
         mismatches   = 0;
         rows_checked = 0;
         products     = 0;
      endfunction

      function void clear_stores();
         foreach (left_bits[i]) left_bits[i] = '0;
         foreach (right_bits[i]) right_bits[i] = '0;
      endfunction

      // Register values above the store size behave as the store size.
      function int span_of(csr_index_type idx);
         logic [CFG_W-1:0] v;
         case (idx)
            CSR_LEFT_ROWS:  v = dim_rows;
            CSR_INNER_SIZE: v = dim_inner;
            default:        v = dim_cols;
         endcase
         return (v > 5'd16) ? 16 : int'(v);
      endfunction

      function void set_dim(csr_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_LEFT_ROWS:  dim_rows  = value;
            CSR_INNER_SIZE: dim_inner = value;
            CSR_RIGHT_COLS: dim_cols  = value;
            default: ;
         endcase
      endfunction

      function void note_item(opcode_type op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
         int               nrows;
         int               ninner;
         int               ncols;
         int               i;
         int               k;
         logic [MASK_W-1:0] acc;
         logic [MASK_W-1:0] col_limit;
         product_row_type  expected_row;
         nrows     = span_of(CSR_LEFT_ROWS);
         ninner    = span_of(CSR_INNER_SIZE);
         ncols     = span_of(CSR_RIGHT_COLS);
         col_limit = MASK_W'((17'd1 << ncols) - 17'd1);
         case (op)
            OP_LEFT: begin
               if (r < nrows && c < ninner) left_bits[r][c] = 1'b1;
            end
            OP_RIGHT: begin
               if (r < ninner && c < ncols) right_bits[r][c] = 1'b1;
            end
            OP_COMPUTE: begin
               products++;
               // Left bits at or above the inner size never select a right
               // row, and right rows at or above it are never read.
               for (i = 0; i < nrows; i++) begin
                  acc = '0;
                  for (k = 0; k < ninner; k++) begin
                     if (left_bits[i][k]) acc |= right_bits[k];
                  end
                  expected_row.row  = ROW_W'(i);
                  expected_row.mask = acc & col_limit;
                  expected_row.last = (i == nrows - 1);
                  rows_due = {rows_due, expected_row};
               end
               clear_stores();
            end
            default: ;
         endcase
      endfunction

      function void check_row(logic [ROW_W-1:0] r, logic [MASK_W-1:0] m, logic l);
         product_row_type want;
         if (rows_due.size() == 0) begin
            mismatches++;
            $display("%t: unexpected row: expected none, got row %0d mask %h last %b",
                     $time, r, m, l);
         end else begin
            want = rows_due.pop_front();
            rows_checked++;
            if (want.row !== r || want.mask !== m || want.last !== l) begin
               mismatches++;
               $display("%t: row mismatch: expected row %0d mask %h last %b,",
                        $time, want.row, want.mask, want.last,
                        " got row %0d mask %h last %b", r, m, l);
            end
         end
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      // Rows still owed at the end of the run are failures.
      function void close_out();
         if (rows_due.size() != 0) begin
            mismatches += rows_due.size();
            $display("%t: %0d rows never arrived, oldest expected row %0d mask %h last %b",
                     $time, rows_due.size(), rows_due[0].row, rows_due[0].mask,
                     rows_due[0].last);
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic [OPCODE_W-1:0]  req_opcode   = OP_LEFT;
   logic [ROW_W-1:0]     req_row      = '0;
   logic [COL_W-1:0]     req_col      = '0;
   logic                 csr_valid    = 1'b0;
   csr_index_type        csr_index    = CSR_LEFT_ROWS;
   logic [CFG_W-1:0]     csr_data     = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [ROW_W-1:0]     rsp_out_row;
   logic [MASK_W-1:0]    rsp_col_mask;
   logic                 rsp_last;
   logic                 csr_ready;

   product_predictor predictor;
   int               items_sent  = 0;
   int               csr_writes  = 0;
   int               burst_left  = 0;

   sparsity_pattern_product_core dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_row      (req_row),
      .req_col      (req_col),
      .rsp_valid    (rsp_valid),
      .rsp_out_row  (rsp_out_row),
      .rsp_col_mask (rsp_col_mask),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   // The result side cannot be stalled, so every cycle with rsp_valid high is
   // a transfer. Outputs are read just after the edge, before any update
   // that the edge schedules, so they hold the values seen at that edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) predictor.check_row(rsp_out_row, rsp_col_mask, rsp_last);
   end

   // Presents one command and holds it until a transfer happens, that is,
   // until an edge at which busy is low. start is left high so that a
   // following command can go out on the very next cycle.
   task automatic send_item(opcode_type op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      start      <= 1'b1;
      req_opcode <= op;
      req_row    <= r;
      req_col    <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      predictor.note_item(op, r, c);
      if (op != OP_NOP) items_sent++;
   endtask

   // The sender works in bursts. When a burst runs out it drops start for a
   // random gap and then picks the length of the next burst. Some bursts are
   // long, which gives stretches with no idling at all.
   task automatic feed(opcode_type op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      send_item(op, r, c);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
      end
   endtask

   // Stops the sender and waits until the block has nothing left to do.
   task automatic park();
      start <= 1'b0;
      @(posedge clock);
      while (predictor.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One register write. csr_valid stays high afterwards; the caller drops it
   // once its last write is done, so a run of writes takes one per cycle.
   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      predictor.set_dim(idx, value);
      csr_writes++;
   endtask

   task automatic set_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                           logic [CFG_W-1:0] cols);
      write_csr(CSR_LEFT_ROWS, rows);
      write_csr(CSR_INNER_SIZE, inner);
      write_csr(CSR_RIGHT_COLS, cols);
      csr_valid <= 1'b0;
   endtask

   // Mostly ordinary sizes, sometimes the full size, one, zero or a value
   // past the store size that has to saturate.
   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
         1:       return 5'd16;
         2:       return 5'd1;
         default: return 5'($urandom_range(1, 16));
      endcase
   endfunction

   // A random load. Most entries land inside the current sizes so that they
   // show up in the product; the rest are anywhere, and a few commands are
   // the ignored opcode.
   task automatic feed_random_load();
      opcode_type op;
      int         rlim;
      int         clim;
      logic [3:0] r;
      logic [3:0] c;
      op   = $urandom_range(0, 1) ? OP_RIGHT : OP_LEFT;
      rlim = predictor.span_of(op == OP_LEFT ? CSR_LEFT_ROWS : CSR_INNER_SIZE);
      clim = predictor.span_of(op == OP_LEFT ? CSR_INNER_SIZE : CSR_RIGHT_COLS);
      if ($urandom_range(0, 7) == 0 || rlim == 0 || clim == 0) begin
         r = 4'($urandom_range(0, 15));
         c = 4'($urandom_range(0, 15));
      end else begin
         r = 4'($urandom_range(0, rlim - 1));
         c = 4'($urandom_range(0, clim - 1));
      end
      if ($urandom_range(0, 19) == 0) op = OP_NOP;
      feed(op, r, c);
   endtask

   initial begin
      int n;
      int loads;
      predictor = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A compute on empty stores at the reset sizes gives
      // sixteen zero rows.
      feed(OP_COMPUTE, 4'd0, 4'd0);
      // Corner entries, a duplicate that must change nothing, and the
      // ignored opcode with every field bit set.
      feed(OP_LEFT, 4'd0, 4'd0);
      feed(OP_LEFT, 4'd15, 4'd15);
      feed(OP_LEFT, 4'd0, 4'd15);
      feed(OP_LEFT, 4'd0, 4'd0);
      feed(OP_RIGHT, 4'd0, 4'd0);
      feed(OP_RIGHT, 4'd15, 4'd15);
      feed(OP_RIGHT, 4'd15, 4'd0);
      feed(OP_NOP, 4'd15, 4'd15);
      feed(OP_COMPUTE, 4'd0, 4'd0);

      // With no left rows a compute yields nothing but still clears both
      // stores; a following one-row product must then come out empty.
      feed(OP_LEFT, 4'd0, 4'd0);
      feed(OP_RIGHT, 4'd0, 4'd5);
      park();
      write_csr(CSR_LEFT_ROWS, 5'd0);
      csr_valid <= 1'b0;
      feed(OP_COMPUTE, 4'd0, 4'd0);
      park();
      set_dims(5'd1, 5'd1, 5'd1);
      feed(OP_COMPUTE, 4'd0, 4'd0);

      // Smallest sizes: entries one past the edge on either index are
      // dropped, only the corner entry survives.
      feed(OP_LEFT, 4'd1, 4'd0);
      feed(OP_LEFT, 4'd0, 4'd1);
      feed(OP_LEFT, 4'd0, 4'd0);
      feed(OP_RIGHT, 4'd1, 4'd0);
      feed(OP_RIGHT, 4'd0, 4'd1);
      feed(OP_RIGHT, 4'd0, 4'd0);
      feed(OP_COMPUTE, 4'd0, 4'd0);

      // Sizes past the store size saturate; the unused register index is
      // written too. Then the sizes shrink between loading and computing,
      // so the product must use the sizes in force at the compute.
      park();
      set_dims(5'd31, 5'd31, 5'd31);
      write_csr(CSR_UNUSED, 5'd31);
      csr_valid <= 1'b0;
      feed(OP_LEFT, 4'd4, 4'd3);
      feed(OP_LEFT, 4'd2, 4'd12);
      feed(OP_RIGHT, 4'd3, 4'd7);
      feed(OP_RIGHT, 4'd12, 4'd1);
      park();
      set_dims(5'd5, 5'd4, 5'd8);
      feed(OP_COMPUTE, 4'd0, 4'd0);

      // Random part: each round loads a handful of entries and computes.
      // Most rounds pick new sizes first; some go straight on, so loads
      // queue up behind a product that is still being emitted; a few change
      // one size between the loads and the compute.
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 2) != 0) begin
            park();
            set_dims(pick_dim(), pick_dim(), pick_dim());
         end
         loads = $urandom_range(0, 14);
         for (n = 0; n < loads; n++) feed_random_load();
         if ($urandom_range(0, 4) == 0) begin
            park();
            write_csr(csr_index_type'($urandom_range(0, 2)), pick_dim());
            csr_valid <= 1'b0;
         end
         feed(OP_COMPUTE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end

      // Drain: wait for every owed row, with a bound, then a few more cycles
      // in case something unexpected still comes out.
      start <= 1'b0;
      for (n = 0; n < 4000 && predictor.pending() != 0; n++) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      predictor.close_out();

      $display("Covered %0d command transfers and %0d products, %0d rows checked.",
               items_sent, predictor.products, predictor.rows_checked);
      $display("Made %0d register writes; %0d mismatches seen.",
               csr_writes, predictor.mismatches);
      if (predictor.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Guard against a hang; a correct run ends far sooner.
   initial begin
      #1_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

`default_nettype wire
